[sv/wspc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wspc_pkg;

    // Default number of wheel lanes.
    localparam int WHEELS_DEF = 2;

    // Field widths of the streams.
    localparam int SPEED_W      = 16;
    localparam int DT_W         = 16;
    localparam int DRIVE_W      = 14;
    localparam int FIELD_PAIR_W = 2 * SPEED_W;

    // Internal arithmetic widths.
    localparam int ACC_W   = 42;
    localparam int STATE_W = 32;
    localparam int FRAC_W  = 12;
    localparam int GAIN_SH = 4;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATIC_FF     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_FF   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLEW_RATE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_BAND    = 3'd6;

    localparam logic [12:0] DRIVE_LIMIT_RST = 13'd4096;

    // Targets strictly inside this magnitude stop the wheel.
    localparam logic signed [SPEED_W-1:0] STOP_LIM = 16'sd4;

    // Sequencer step codes shared by all lanes.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE = 4'd0;
    localparam logic [STEP_W-1:0] STEP_ERR  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MUL  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SUM  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_PRE  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_INT  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_PI   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SLEW = 4'd7;
    localparam logic [STEP_W-1:0] STEP_OUT  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DONE = 4'd9;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integral_gain;
        logic [12:0] static_ff;
        logic [15:0] velocity_ff;
        logic [12:0] drive_limit;
        logic [15:0] slew_rate;
        logic [11:0] error_band;
    } cfg_t;

    typedef struct packed {
        logic              load;
        logic [STEP_W-1:0] step;
    } lane_ctrl_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
        logic                      slewed;
    } lane_res_t;

    // Saturate a wide signed value to the 32-bit state range.
    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = (ACC_W'(1) <<< (STATE_W - 1)) - ACC_W'(1);
        lo = -(ACC_W'(1) <<< (STATE_W - 1));
        if (v > hi) begin
            return hi[STATE_W-1:0];
        end else if (v < lo) begin
            return lo[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/wheel_speed_pi_controller_top.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake         Content
// s_        in         s_tvalid/tready   per wheel target and measured speed, interval
// m_        out        m_tvalid/tready   per wheel drive in tdata, clamp and slew flags in tuser
// cfg_      in         cfg_valid/ready   register index and write data
//
// Each item walks a 9-step sequence (error, products, sums, pre-check, integrate, PI,
// slew, output, hand-off), then the sequencer is free; hand-off waits for a free output.
// All wheels run in lockstep through the shared step sequence.
// Reset (aresetn low, synchronous) clears the wheel state and loads register defaults.
// A stalled output holds the finished item; the next item is taken once it has moved on.

module wheel_speed_pi_controller_top
    import wspc_pkg::*;
#(
    parameter  int WHEELS = WHEELS_DEF,
    localparam int IN_W   = FIELD_PAIR_W * WHEELS + DT_W,
    localparam int OUT_DW = ((DRIVE_W * WHEELS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // target, measured per wheel (wheel 0 first), then interval
    input  wire logic [IN_W-1:0]       s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // drive per wheel, wheel 0 first, zero padded
    output logic [OUT_DW-1:0]          m_tdata,
    // clamped per wheel, then slewed per wheel
    output logic [2*WHEELS-1:0]        m_tuser,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t              cfg_reg;
    logic [STEP_W-1:0] state_reg, state_next;
    logic [DT_W-1:0]   dt_reg;
    logic              s_accept, out_free, out_load;
    lane_ctrl_t        lane_ctrl;
    lane_res_t         lane_res [WHEELS];

    // Neither input channel takes anything while reset is held.
    assign s_tready  = aresetn && (state_reg == STEP_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = aresetn;
    assign out_load  = (state_reg == STEP_DONE) && out_free;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{drive_limit: DRIVE_LIMIT_RST, default: '0};
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_PROP_GAIN:     cfg_reg.prop_gain     <= cfg_data;
                REG_INTEGRAL_GAIN: cfg_reg.integral_gain <= cfg_data;
                REG_STATIC_FF:     cfg_reg.static_ff     <= cfg_data[12:0];
                REG_VELOCITY_FF:   cfg_reg.velocity_ff   <= cfg_data;
                REG_DRIVE_LIMIT:   cfg_reg.drive_limit   <= cfg_data[12:0];
                REG_SLEW_RATE:     cfg_reg.slew_rate     <= cfg_data;
                REG_ERROR_BAND:    cfg_reg.error_band    <= cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    // Step sequencer shared by all lanes.
    always_comb begin
        unique case (state_reg)
            STEP_IDLE: state_next = s_accept ? STEP_ERR : STEP_IDLE;
            STEP_ERR:  state_next = STEP_MUL;
            STEP_MUL:  state_next = STEP_SUM;
            STEP_SUM:  state_next = STEP_PRE;
            STEP_PRE:  state_next = STEP_INT;
            STEP_INT:  state_next = STEP_PI;
            STEP_PI:   state_next = STEP_SLEW;
            STEP_SLEW: state_next = STEP_OUT;
            STEP_OUT:  state_next = STEP_DONE;
            STEP_DONE: state_next = out_free ? STEP_IDLE : STEP_DONE;
            default:   state_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STEP_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The interval is shared by all wheels.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            dt_reg <= s_tdata[FIELD_PAIR_W*WHEELS +: DT_W];
        end
    end

    assign lane_ctrl.load = s_accept;
    assign lane_ctrl.step = state_reg;

    // One controller lane per wheel.
    for (genvar w = 0; w < WHEELS; w++) begin : g_lane
        wspc_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .cfg     (cfg_reg),
            .tgt_in  (s_tdata[FIELD_PAIR_W*w +: SPEED_W]),
            .meas_in (s_tdata[FIELD_PAIR_W*w + SPEED_W +: SPEED_W]),
            .dt      (dt_reg),
            .res     (lane_res[w])
        );
    end

    // Merge the lanes into the output item.
    wspc_merge #(
        .WHEELS (WHEELS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .res      (lane_res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // An accepted item starts the sequence on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == STEP_ERR))
        else $error("sequencer did not start after an accepted item");

    // A new result only appears after the hand-off step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == STEP_DONE))
        else $error("result appeared outside the hand-off step");

    // A clamped wheel sits exactly on the drive limit.
    for (genvar w = 0; w < WHEELS; w++) begin : g_chk
        assert property (@(posedge aclk) disable iff (!aresetn)
            (m_tvalid && m_tuser[w]) |->
                (($signed(m_tdata[DRIVE_W*w +: DRIVE_W]) ==
                  $signed({1'b0, cfg_reg.drive_limit}))
                 || ($signed(m_tdata[DRIVE_W*w +: DRIVE_W]) ==
                  -$signed({1'b0, cfg_reg.drive_limit}))))
            else $error("clamped drive is not at the limit");
    end

endmodule

`default_nettype wire

[sv/wspc_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module wspc_lane
    import wspc_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire lane_ctrl_t                ctrl,
    input  wire cfg_t                      cfg,
    input  wire logic signed [SPEED_W-1:0] tgt_in,
    input  wire logic signed [SPEED_W-1:0] meas_in,
    input  wire logic [DT_W-1:0]           dt,
    output lane_res_t                      res
);

    localparam int ERR_W  = SPEED_W + 1;
    localparam int PROD_W = 2 * SPEED_W + 2;
    localparam int VPRD_W = 2 * SPEED_W + 1;
    localparam int KDT_W  = PROD_W + DT_W + 1;

    // Item payload and per-step results.
    logic signed [SPEED_W-1:0] tgt_reg, meas_reg;
    logic                      stop_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [PROD_W-1:0]  pprod_reg, kprod_reg;
    logic signed [VPRD_W-1:0]  vprod_reg;
    logic [2*DT_W-1:0]         delta_reg;
    logic signed [ACC_W-1:0]   ff_reg, pterm_reg, inc_reg, pre_reg, isum_reg, pi_reg;
    logic                      slewed_reg, clamped_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    // Wheel state kept across items.
    logic signed [STATE_W-1:0] integ_reg, prev_reg;

    logic signed [ERR_W-1:0]   err_raw, band_s, err_next;
    logic                      stop_next;
    logic signed [PROD_W-1:0]  kp_s, ki_s, err_wide, pprod_next, kprod_next;
    logic signed [VPRD_W-1:0]  kv_s, tgt_wide, vprod_next;
    logic [2*DT_W-1:0]         delta_next;
    logic signed [KDT_W-1:0]   kdt_prod, kprod_wide, dt_s;
    logic signed [ACC_W-1:0]   ks_ext, lim_ext, delta_ext, ff_next, pterm_next, inc_next;
    logic signed [ACC_W-1:0]   pre_next, isum_next, pi_next, hi_bound, lo_bound, pi_sel;
    logic signed [ACC_W-1:0]   sum_raw, sum_clip, sum_rnd;
    logic signed [STATE_W-1:0] integ_next, prev_next;
    logic                      int_ok, slewed_next, clamped_next;
    logic signed [DRIVE_W-1:0] drive_next;

    // Error with deadband and stop detection.
    always_comb begin
        err_raw   = ERR_W'(tgt_reg) - ERR_W'(meas_reg);
        band_s    = ERR_W'({1'b0, cfg.error_band});
        err_next  = ((err_raw < band_s) && (err_raw > -band_s)) ? '0 : err_raw;
        stop_next = (tgt_reg > -STOP_LIM) && (tgt_reg < STOP_LIM);
    end

    // Gain products and slew step size, one multiplier each.
    always_comb begin
        kp_s       = PROD_W'({1'b0, cfg.prop_gain});
        ki_s       = PROD_W'({1'b0, cfg.integral_gain});
        err_wide   = PROD_W'(err_reg);
        kv_s       = VPRD_W'({1'b0, cfg.velocity_ff});
        tgt_wide   = VPRD_W'(tgt_reg);
        pprod_next = kp_s * err_wide;
        kprod_next = ki_s * err_wide;
        vprod_next = kv_s * tgt_wide;
        delta_next = (2*DT_W)'(cfg.slew_rate) * (2*DT_W)'(dt);
    end

    // Feedforward, proportional term and integrator increment.
    always_comb begin
        ks_ext     = ACC_W'({cfg.static_ff, {FRAC_W{1'b0}}});
        ff_next    = ((tgt_reg > 0) ? ks_ext : -ks_ext) + (ACC_W'(vprod_reg) <<< GAIN_SH);
        pterm_next = ACC_W'(pprod_reg) <<< GAIN_SH;
        kprod_wide = KDT_W'(kprod_reg);
        dt_s       = KDT_W'({1'b0, dt});
        kdt_prod   = kprod_wide * dt_s;
        inc_next   = ACC_W'(kdt_prod >>> FRAC_W);
    end

    // Pre-check sum and candidate integrator.
    always_comb begin
        pre_next  = ff_reg + pterm_reg + ACC_W'(integ_reg);
        isum_next = ACC_W'(integ_reg) + inc_reg;
    end

    // Conditional integration keeps the integrator from winding up at the rail.
    always_comb begin
        lim_ext = ACC_W'({cfg.drive_limit, {FRAC_W{1'b0}}});
        int_ok  = ((pre_reg <= lim_ext) && (pre_reg >= -lim_ext))
                  || ((pre_reg > lim_ext) && (err_reg < 0))
                  || ((pre_reg < -lim_ext) && (err_reg > 0));
        if (stop_reg) begin
            integ_next = '0;
        end else if (int_ok) begin
            integ_next = sat32(isum_reg);
        end else begin
            integ_next = integ_reg;
        end
        pi_next = pterm_reg + ACC_W'(integ_reg);
    end

    // Slew limit against the previous correction.
    always_comb begin
        delta_ext   = ACC_W'(delta_reg);
        hi_bound    = ACC_W'(prev_reg) + delta_ext;
        lo_bound    = ACC_W'(prev_reg) - delta_ext;
        pi_sel      = pi_reg;
        slewed_next = 1'b0;
        if (cfg.slew_rate != '0) begin
            if (pi_reg > hi_bound) begin
                pi_sel      = hi_bound;
                slewed_next = 1'b1;
            end else if (pi_reg < lo_bound) begin
                pi_sel      = lo_bound;
                slewed_next = 1'b1;
            end
        end
        if (stop_reg) begin
            prev_next   = '0;
            slewed_next = 1'b0;
        end else begin
            prev_next = sat32(pi_sel);
        end
    end

    // Output sum, clamp and rounding to a signed Q14.0 drive.
    always_comb begin
        sum_raw      = ff_reg + ACC_W'(prev_reg);
        sum_clip     = sum_raw;
        clamped_next = 1'b0;
        if (sum_raw > lim_ext) begin
            sum_clip     = lim_ext;
            clamped_next = 1'b1;
        end else if (sum_raw < -lim_ext) begin
            sum_clip     = -lim_ext;
            clamped_next = 1'b1;
        end
        sum_rnd    = sum_clip + (ACC_W'(1) <<< (FRAC_W - 1));
        drive_next = sum_rnd[FRAC_W +: DRIVE_W];
        if (stop_reg) begin
            drive_next   = '0;
            clamped_next = 1'b0;
        end
    end

    // Step registers, advanced by the shared sequencer.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            tgt_reg  <= tgt_in;
            meas_reg <= meas_in;
        end
        unique case (ctrl.step)
            STEP_ERR: begin
                err_reg  <= err_next;
                stop_reg <= stop_next;
            end
            STEP_MUL: begin
                pprod_reg <= pprod_next;
                kprod_reg <= kprod_next;
                vprod_reg <= vprod_next;
                delta_reg <= delta_next;
            end
            STEP_SUM: begin
                ff_reg    <= ff_next;
                pterm_reg <= pterm_next;
                inc_reg   <= inc_next;
            end
            STEP_PRE: begin
                pre_reg  <= pre_next;
                isum_reg <= isum_next;
            end
            STEP_PI: begin
                pi_reg <= pi_next;
            end
            STEP_SLEW: begin
                slewed_reg <= slewed_next;
            end
            STEP_OUT: begin
                drive_reg   <= drive_next;
                clamped_reg <= clamped_next;
            end
            default: begin
            end
        endcase
    end

    // Integrator and previous correction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end else begin
            if (ctrl.step == STEP_INT) begin
                integ_reg <= integ_next;
            end
            if (ctrl.step == STEP_SLEW) begin
                prev_reg <= prev_next;
            end
        end
    end

    assign res.drive   = drive_reg;
    assign res.clamped = clamped_reg;
    assign res.slewed  = slewed_reg;

endmodule

`default_nettype wire

[sv/wspc_merge.sv]
`timescale 1ns / 1ps
`default_nettype none

module wspc_merge
    import wspc_pkg::*;
#(
    parameter  int WHEELS = WHEELS_DEF,
    localparam int OUT_DW = ((DRIVE_W * WHEELS + 7) / 8) * 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire lane_res_t   res [WHEELS],
    output logic             out_free,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [OUT_DW-1:0]   m_tdata,
    output logic [2*WHEELS-1:0] m_tuser
);

    logic                tvalid_reg;
    logic [OUT_DW-1:0]   tdata_reg, tdata_next;
    logic [2*WHEELS-1:0] tuser_reg, tuser_next;

    // Gather the lane results into one item.
    always_comb begin
        tdata_next = '0;
        tuser_next = '0;
        for (int w = 0; w < WHEELS; w++) begin
            tdata_next[DRIVE_W*w +: DRIVE_W] = res[w].drive;
            tuser_next[w]                    = res[w].clamped;
            tuser_next[WHEELS + w]           = res[w].slewed;
        end
    end

    assign out_free = !tvalid_reg || m_tready;

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (load) begin
            tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tdata_reg <= tdata_next;
            tuser_reg <= tuser_next;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;

endmodule

`default_nettype wire
